// ===== src/swr_pkg.sv =====
// Shared types and constants for the sample-without-replacement block.
`timescale 1ns / 1ps
package swr_pkg;

  localparam int VAL_W = 9;
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;
  localparam int ST_W  = 2;
  localparam int CFG_W = 9;

  localparam logic CMD_DRAW  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_DONE  = 2'd2;
  localparam logic [ST_W-1:0] ST_K_OVR = 2'd3;

  localparam logic CFG_TOTAL = 1'b0;
  localparam logic CFG_PICK  = 1'b1;

  localparam logic [CFG_W-1:0] TOTAL_RST = 9'd256;
  localparam logic [CFG_W-1:0] PICK_RST  = 9'd256;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] draw;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] picked_index;
    logic [CNT_W-1:0] picked_so_far;
    logic             last_pick;
    logic [ST_W-1:0]  status;
  } out_req_t;

  typedef struct packed {
    logic             ins;
    logic [IDX_W-1:0] rank;
    logic [CNT_W-1:0] fill;
  } cell_ctl_t;

endpackage

// ===== src/swr_cell.sv =====
// One cell of the sorted pick row: compare against the rank, insert or shift right.
`timescale 1ns / 1ps
module swr_cell #(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  swr_pkg::cell_ctl_t       ctl,
  input  logic                     ge_left,
  input  logic [swr_pkg::VAL_W-1:0] val_left,
  output logic                     ge,
  output logic [swr_pkg::VAL_W-1:0] val,
  output logic [swr_pkg::VAL_W-1:0] contrib
);
  import swr_pkg::*;

  localparam int CW = $clog2(IDX + 257) + 2;

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;
  logic             vld;
  logic             bnd;
  logic [CW-1:0]    thr;

  // cell holds a real pick when its slot is below the fill count
  assign vld = CW'(IDX) < CW'(ctl.fill);
  assign thr = CW'(ctl.rank) + CW'(IDX);
  // ge: the requested unpicked index lies above this pick
  assign ge  = vld && (CW'(val_r) <= thr);
  assign bnd = ge_left && !ge;

  assign contrib = bnd ? VAL_W'(thr) : '0;
  assign val     = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (bnd) begin
        val_nxt = VAL_W'(thr);
      end else if (!ge_left) begin
        val_nxt = val_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== src/swr_group.sv =====
// Registered OR reduction over one group of cell contributions.
`timescale 1ns / 1ps
module swr_group #(
  parameter int GRP = 16
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [GRP-1:0][swr_pkg::VAL_W-1:0] vec,
  output logic [swr_pkg::VAL_W-1:0]          q
);
  import swr_pkg::*;

  logic [VAL_W-1:0] q_r;
  logic [VAL_W-1:0] q_nxt;

  always_comb begin
    q_nxt = '0;
    for (int i = 0; i < GRP; i++) begin
      q_nxt = q_nxt | vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== src/sample_without_replacement.sv =====
// Top level: picks k of N indices without replacement using a row of sorted cells.
// A draw is accepted, then passes through an insert state in which every cell
// compares its stored pick with the rank, the boundary cell takes the new index and the
// cells above it shift right, while per-group OR registers catch the new index. The
// result is loaded into the output register in the finish state once the output
// register is free, and in that cycle the next request may already be accepted. Clears
// and rejected draws go straight to the finish state. The output register holds a
// finished result while the next request is accepted. No clearing pass runs after reset.
`timescale 1ns / 1ps
module sample_without_replacement #(
  parameter int MAX_N = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  swr_pkg::in_req_t         in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output swr_pkg::out_req_t        out_data,
  input  logic                     cfg_we,
  input  logic                     cfg_addr,
  input  logic [swr_pkg::CFG_W-1:0] cfg_wdata
);
  import swr_pkg::*;

  localparam int GRP  = (MAX_N < 16) ? MAX_N : 16;
  localparam int NGRP = (MAX_N + GRP - 1) / GRP;
  localparam int NSAT = (MAX_N > 511) ? 511 : MAX_N;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CFG_W-1:0] total_r, pick_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_req_t         out_data_r;
  logic [IDX_W-1:0] rank_r;
  logic [ST_W-1:0]  st_r;
  logic             ok_r;

  logic             acc;
  logic             out_free;
  logic [ST_W-1:0]  st_new;
  logic             ok_new;
  logic [CNT_W-1:0] n_sat;

  cell_ctl_t                       ctl;
  logic [MAX_N:0]                  ge;
  logic [MAX_N:0][VAL_W-1:0]       val;
  logic [NGRP*GRP-1:0][VAL_W-1:0]  contrib;
  logic [NGRP-1:0][VAL_W-1:0]      grp_q;
  logic [VAL_W-1:0]                new_idx;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_FIN) && out_free);
  assign acc      = in_valid && in_ready;

  assign n_sat = (total_r > CNT_W'(NSAT)) ? CNT_W'(NSAT) : total_r;

  always_comb begin
    st_new = ST_OK;
    ok_new = 1'b0;
    if (in_data.cmd == CMD_CLEAR) begin
      st_new = ST_OK;
    end else if (pick_r > n_sat) begin
      st_new = ST_K_OVR;
    end else if (fill_r >= pick_r || fill_r >= CNT_W'(NSAT)) begin
      st_new = ST_DONE;
    end else if ((CNT_W + 1)'(in_data.draw) + (CNT_W + 1)'(fill_r) >=
                 (CNT_W + 1)'(n_sat)) begin
      st_new = ST_RANGE;
    end else begin
      ok_new = 1'b1;
    end
  end

  // cell row
  assign ctl.ins  = (state_r == S_INS);
  assign ctl.rank = rank_r;
  assign ctl.fill = fill_r;
  assign ge[0]    = 1'b1;
  assign val[0]   = '0;

  for (genvar i = 0; i < MAX_N; i++) begin : g_cell
    swr_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .ge_left (ge[i]),
      .val_left(val[i]),
      .ge      (ge[i+1]),
      .val     (val[i+1]),
      .contrib (contrib[i])
    );
  end

  for (genvar i = MAX_N; i < NGRP * GRP; i++) begin : g_pad
    assign contrib[i] = '0;
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    swr_group #(.GRP(GRP)) u_grp (
      .clk(clk),
      .en (state_r == S_INS),
      .vec(contrib[g*GRP +: GRP]),
      .q  (grp_q[g])
    );
  end

  always_comb begin
    new_idx = '0;
    for (int g = 0; g < NGRP; g++) begin
      new_idx = new_idx | grp_q[g];
    end
  end

  // control
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
      end
      S_INS: begin
        fill_nxt  = fill_r + 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (acc) begin
      state_nxt = ok_new ? S_INS : S_FIN;
      if (in_data.cmd == CMD_CLEAR) begin
        fill_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      total_r     <= TOTAL_RST;
      pick_r      <= PICK_RST;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TOTAL: total_r <= cfg_wdata;
          CFG_PICK:  pick_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rank_r <= in_data.draw;
      st_r   <= st_new;
      ok_r   <= ok_new;
    end
    if (state_r == S_FIN && out_free) begin
      out_data_r.picked_index  <= ok_r ? new_idx[IDX_W-1:0] : '0;
      out_data_r.picked_so_far <= fill_r;
      out_data_r.last_pick     <= ok_r && (fill_r == pick_r);
      out_data_r.status        <= st_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/swr_check.sv =====
// Port-level checks for the sample-without-replacement block, bound to the top level.
`timescale 1ns / 1ps
module swr_check (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input swr_pkg::in_req_t         in_data,
  input logic                     out_valid,
  input logic                     out_ready,
  input swr_pkg::out_req_t        out_data
);
  import swr_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request dropped or changed while waiting");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.picked_index == '0 && !out_data.last_pick)
    else $error("rejected request carries an index or last flag");

  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_pick |->
      out_data.status == ST_OK && out_data.picked_so_far != '0)
    else $error("last pick without a successful draw");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sample_without_replacement swr_check u_swr_check (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
